>>> rtl/core/dpp_pkg.sv
// Shared types and constants for the depth pixel to point block.
package dpp_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_INV_DEPTH_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y     = 3'd4;

  localparam logic [15:0] NO_DEPTH = 16'd4096;

  typedef struct packed {
    logic [31:0] inv_depth_scale;
    logic [15:0] principal_x;
    logic [15:0] principal_y;
    logic [31:0] inv_focal_x;
    logic [31:0] inv_focal_y;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    inv_depth_scale: 32'd16777,
    principal_x:     16'd0,
    principal_y:     16'd0,
    inv_focal_x:     32'd16777216,
    inv_focal_y:     32'd16777216
  };

endpackage

>>> rtl/core/dpp_depth.sv
// Depth stage: raw depth times reciprocal scale, rounded and saturated to Q.FRAC_BITS.
module dpp_depth #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic [15:0] depth_i,
  input  logic [31:0] scale_i,
  output logic [31:0] z_o
);

  localparam int unsigned ZF_SHIFT = 24 - FRAC_BITS;
  localparam logic [48:0] ZHALF    = (49'(1) << ZF_SHIFT) >> 1;

  logic [47:0] prod_q;
  logic [48:0] rsum;
  logic [48:0] zsh;
  logic [31:0] z_q;

  assign rsum = {1'b0, prod_q} + ZHALF;
  assign zsh  = rsum >> ZF_SHIFT;

  always_ff @(posedge clk_i) begin
    prod_q <= depth_i * scale_i;
    z_q    <= (|zsh[48:31]) ? 32'h7FFF_FFFF : {1'b0, zsh[30:0]};
  end

  assign z_o = z_q;

endmodule

>>> rtl/core/dpp_lateral.sv
// Lateral axis: offset from principal point, times z, times reciprocal focal, round, saturate.
module dpp_lateral #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic [COORD_BITS-1:0] coord_i,
  input  logic [15:0]           centre_i,
  input  logic [31:0]           inv_f_i,
  input  logic [30:0]           z_i,
  output logic signed [31:0]    coord_o
);

  localparam int unsigned DW = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
  localparam int unsigned AW = DW + 31;
  localparam int unsigned SW = AW + 5;

  logic [DW-1:0] pos;
  logic [DW-1:0] cen;
  logic          neg;
  logic [DW-1:0] mag_d;

  logic [DW-1:0] mag1_q, mag2_q;
  logic          neg1_q, neg2_q, neg3_q, neg4_q;
  logic [AW-1:0] a_q;
  logic [63:0]   plo_q;
  logic [AW-1:0] phi_q;

  logic [63:0]   rnd;
  logic [SW-1:0] sum;
  logic [31:0]   res_d;
  logic [31:0]   res_q;

  assign pos   = DW'({coord_i, 4'b0000});
  assign cen   = DW'(centre_i);
  assign neg   = pos < cen;
  assign mag_d = neg ? (cen - pos) : (pos - cen);

  assign rnd = plo_q + 64'h0000_0000_0800_0000;
  assign sum = SW'({phi_q, 4'b0000}) + SW'(rnd[63:28]);

  always_comb begin
    if (neg4_q) begin
      if (sum > SW'(32'h8000_0000)) begin
        res_d = 32'h8000_0000;
      end else begin
        res_d = ~sum[31:0] + 32'd1;
      end
    end else begin
      if (|sum[SW-1:31]) begin
        res_d = 32'h7FFF_FFFF;
      end else begin
        res_d = sum[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag1_q <= mag_d;
    neg1_q <= neg;
    mag2_q <= mag1_q;
    neg2_q <= neg1_q;
    a_q    <= mag2_q * z_i;
    neg3_q <= neg2_q;
    plo_q  <= a_q[31:0] * inv_f_i;
    phi_q  <= a_q[AW-1:32] * inv_f_i;
    neg4_q <= neg3_q;
    res_q  <= res_d;
  end

  assign coord_o = res_q;

endmodule

>>> rtl/core/depth_pixel_to_point_core.sv
// Top level: depth pixel back-projection pipeline with configuration registers.
// One item is taken every clock; busy is always low. An item with a raw depth
// of 0 or 4096 gives no result. Every other item gives one point, strobed on
// point_valid_o for one cycle once the item has passed the five-stage
// multiply chain (z, offset times z, two partial products against the focal
// reciprocal, round and saturate). Results cannot be held off. Write
// configuration only while no item is in flight.
module depth_pixel_to_point_core #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dpp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dpp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               start,
  output logic                               busy,
  input  logic [15:0]                        depth_raw_i,
  input  logic [COORD_BITS-1:0]              column_i,
  input  logic [COORD_BITS-1:0]              row_i,
  input  logic [7:0]                         blue_i,
  input  logic [7:0]                         green_i,
  input  logic [7:0]                         red_i,
  output logic                               point_valid_o,
  output logic signed [31:0]                 point_x_o,
  output logic signed [31:0]                 point_y_o,
  output logic signed [31:0]                 point_z_o,
  output logic [7:0]                         out_blue_o,
  output logic [7:0]                         out_green_o,
  output logic [7:0]                         out_red_o
);

  localparam int unsigned LAT = 5;

  dpp_pkg::cfg_t cfg_q;

  logic           accept;
  logic           present;
  logic [LAT-1:0] valid_q;
  logic [LAT-1:0] valid_d;
  logic [23:0]    color_q [LAT];
  logic [31:0]    z2;
  logic [31:0]    z3_q, z4_q, z5_q;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign present = (depth_raw_i != 16'd0) && (depth_raw_i != dpp_pkg::NO_DEPTH);
  assign valid_d = {valid_q[LAT-2:0], accept && present};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= dpp_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dpp_pkg::REG_INV_DEPTH_SCALE: cfg_q.inv_depth_scale <= cfg_wdata_i;
        dpp_pkg::REG_PRINCIPAL_X:     cfg_q.principal_x     <= cfg_wdata_i[15:0];
        dpp_pkg::REG_PRINCIPAL_Y:     cfg_q.principal_y     <= cfg_wdata_i[15:0];
        dpp_pkg::REG_INV_FOCAL_X:     cfg_q.inv_focal_x     <= cfg_wdata_i;
        dpp_pkg::REG_INV_FOCAL_Y:     cfg_q.inv_focal_y     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q[0] <= {blue_i, green_i, red_i};
    for (int i = 1; i < LAT; i++) begin
      color_q[i] <= color_q[i-1];
    end
    z3_q <= z2;
    z4_q <= z3_q;
    z5_q <= z4_q;
  end

  dpp_depth #(
    .FRAC_BITS(FRAC_BITS)
  ) u_depth (
    .clk_i   (clk_i),
    .depth_i (depth_raw_i),
    .scale_i (cfg_q.inv_depth_scale),
    .z_o     (z2)
  );

  dpp_lateral #(
    .COORD_BITS(COORD_BITS)
  ) u_lat_x (
    .clk_i    (clk_i),
    .coord_i  (column_i),
    .centre_i (cfg_q.principal_x),
    .inv_f_i  (cfg_q.inv_focal_x),
    .z_i      (z2[30:0]),
    .coord_o  (point_x_o)
  );

  dpp_lateral #(
    .COORD_BITS(COORD_BITS)
  ) u_lat_y (
    .clk_i    (clk_i),
    .coord_i  (row_i),
    .centre_i (cfg_q.principal_y),
    .inv_f_i  (cfg_q.inv_focal_y),
    .z_i      (z2[30:0]),
    .coord_o  (point_y_o)
  );

  assign point_valid_o = valid_q[LAT-1];
  assign point_z_o     = z5_q;
  assign out_blue_o    = color_q[LAT-1][23:16];
  assign out_green_o   = color_q[LAT-1][15:8];
  assign out_red_o     = color_q[LAT-1][7:0];

endmodule
